### src/mchull_pkg.sv
package mchull_pkg;

  localparam int MaxPoints  = 64;
  localparam int CoordBits  = 16;
  localparam int StackDepth = 2 * MaxPoints;
  localparam int PtrW       = $clog2(MaxPoints);
  localparam int CntW       = $clog2(MaxPoints + 1);
  localparam int SpW        = $clog2(StackDepth + 1);
  localparam int SaW        = $clog2(StackDepth);

  localparam logic       OpAdd  = 1'b0;
  localparam logic       OpRead = 1'b1;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StNoHull   = 3'd1;
  localparam logic [2:0] StRange    = 3'd2;
  localparam logic [2:0] StOverflow = 3'd3;
  localparam logic [2:0] StFew      = 3'd4;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               final_point;
    logic [6:0]         vertex_index;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [6:0]         upper_count;
    logic [6:0]         vertex_count;
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
  } rsp_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
  } pt_t;

endpackage

### src/monotone_chain_convex_hull_core.sv
// Monotone chain convex hull core. Add item: result in the cycle after the transfer, busy low,
// one add per cycle; a final point with overflow or fewer than two points answers the same way.
// Build on a final point: S_INIT, S_INIT1, then per chain point S_PT to S_FIN, S_TOPA to S_TST
// skipped without a turn test and rerun per pop; busy throughout, result in the cycle after the
// last S_FIN. Read item: result and busy in the cycle after the transfer; no receiver stall.
// Reset (rst_ni low, asynchronous) clears counts and ready_q; memories are not cleared.
module monotone_chain_convex_hull_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  mchull_pkg::cmd_t   cmd_i,
  output logic               done_o,
  output mchull_pkg::rsp_t   rsp_o
);
  localparam int PtrW = mchull_pkg::PtrW;
  localparam int CntW = mchull_pkg::CntW;
  localparam int SpW  = mchull_pkg::SpW;
  localparam int SaW  = mchull_pkg::SaW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_INIT  = 4'd2;
  localparam logic [3:0] S_INIT1 = 4'd3;
  localparam logic [3:0] S_PT    = 4'd4;
  localparam logic [3:0] S_TOPA  = 4'd5;
  localparam logic [3:0] S_TOPB  = 4'd6;
  localparam logic [3:0] S_TST   = 4'd7;
  localparam logic [3:0] S_DEC   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  mchull_pkg::pt_t point_mem [mchull_pkg::MaxPoints];
  mchull_pkg::pt_t stack_mem [mchull_pkg::StackDepth];

  logic [3:0]      state_q, state_d;
  logic            done_d;
  logic [CntW-1:0] ptot_q;
  logic            ovf_q;
  logic            ready_q;
  logic [SpW-1:0]  upper_q, chain_q;
  logic [SpW-1:0]  sp_q, top_q;
  logic            lower_q;
  logic [PtrW:0]   k_q;         // signed-ish walk index, extra bit for -1
  logic [CntW-1:0] n_q;
  logic [1:0]      ini_q;

  // memory ports
  logic            pm_we;
  logic [PtrW-1:0] pm_wa, pm_ra;
  mchull_pkg::pt_t pm_wd, pm_rd_q;
  logic            sm_we;
  logic [SaW-1:0]  sm_wa, sm_ra;
  mchull_pkg::pt_t sm_wd, sm_rd_q;

  always_ff @(posedge clk_i) begin
    if (pm_we) point_mem[pm_wa] <= pm_wd;
    pm_rd_q <= point_mem[pm_ra];
    if (sm_we) stack_mem[sm_wa] <= sm_wd;
    sm_rd_q <= stack_mem[sm_ra];
  end

  mchull_pkg::pt_t p_q, a_q;
  logic            right;

  mchull_turn u_turn (
    .clk_i   (clk_i),
    .a_i     (a_q),
    .b_i     (sm_rd_q),
    .c_i     (p_q),
    .right_o (right)
  );

  logic             acc;
  logic             add_full;
  mchull_pkg::pt_t  in_pt;
  logic [CntW-1:0]  ptot_inc;
  logic             pop_ok;
  assign acc      = start && !busy;
  assign add_full = ptot_q >= CntW'(mchull_pkg::MaxPoints);
  assign in_pt.x  = cmd_i.point_x[mchull_pkg::CoordBits-1:0];
  assign in_pt.y  = cmd_i.point_y[mchull_pkg::CoordBits-1:0];
  assign ptot_inc = add_full ? ptot_q : ptot_q + CntW'(1);
  assign busy     = state_q != S_IDLE;
  assign pop_ok   = lower_q ? (sp_q > top_q) : (sp_q > SpW'(1));

  // point index into memory
  logic [PtrW-1:0] kidx;
  assign kidx = k_q[PtrW-1:0];

  always_comb begin
    state_d = state_q;
    done_d = 1'b0;
    pm_we = 1'b0; pm_wa = ptot_q[PtrW-1:0]; pm_wd = in_pt; pm_ra = kidx;
    sm_we = 1'b0; sm_wa = sp_q[SaW-1:0]; sm_wd = pm_rd_q;
    sm_ra = cmd_i.vertex_index[SaW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (acc && cmd_i.opcode == mchull_pkg::OpAdd && !add_full) pm_we = 1'b1;
        if (acc && cmd_i.opcode == mchull_pkg::OpRead) state_d = S_RD;
        if (acc && cmd_i.opcode == mchull_pkg::OpAdd && cmd_i.final_point &&
            !(ovf_q || add_full) && ptot_inc >= CntW'(2)) state_d = S_INIT;
        done_d = acc && (state_d != S_INIT);
      end
      S_RD: state_d = S_IDLE;
      S_INIT: state_d = S_INIT1;  // reads point 0 (k=0)
      S_INIT1: begin               // write pt k, advance
        sm_we = 1'b1;
        state_d = (ini_q == 2'd1) ? S_PT : S_INIT1;
      end
      S_PT: begin                  // pm_rd_q holds new point p; read stack top-2
        sm_ra = SaW'(sp_q - SpW'(2));
        state_d = pop_ok ? S_TOPA : S_DEC;
      end
      S_TOPA: begin
        sm_ra = SaW'(sp_q - SpW'(1));
        state_d = S_TOPB;
      end
      S_TOPB: state_d = S_TST;     // turn products computing
      S_TST: begin
        if (right) state_d = S_DEC;
        else begin
          sm_ra = SaW'(sp_q - SpW'(3));
          state_d = (lower_q ? (sp_q - SpW'(1) > top_q) : (sp_q - SpW'(1) > SpW'(1)))
                    ? S_TOPA : S_DEC;
        end
      end
      S_DEC: begin                 // push p, advance to next point
        sm_we = 1'b1; sm_wd = p_q;
        state_d = S_FIN;
      end
      S_FIN: begin                 // lower chain past point 0 ends the build
        if (lower_q && k_q[PtrW]) begin
          state_d = S_IDLE;
          done_d = 1'b1;
        end else begin
          state_d = S_PT;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_TST && !right) sm_ra = SaW'(sp_q - SpW'(3));
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ptot_q <= '0; ovf_q <= 1'b0; ready_q <= 1'b0;
      upper_q <= '0; chain_q <= '0; sp_q <= '0; top_q <= '0; lower_q <= 1'b0;
      k_q <= '0; n_q <= '0; ini_q <= '0; done_o <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= done_d;
      unique case (state_q)
        S_IDLE: if (acc) begin
          if (cmd_i.opcode == mchull_pkg::OpAdd) begin
            if (cmd_i.final_point) begin
              ptot_q <= '0; ovf_q <= 1'b0;
              if (state_d == S_INIT) begin
                n_q <= ptot_inc; k_q <= '0; sp_q <= '0; lower_q <= 1'b0;
                ini_q <= 2'd0;
              end else begin
                ready_q <= 1'b0; upper_q <= '0; chain_q <= '0;
              end
            end else begin
              ptot_q <= ptot_inc;
              if (add_full) ovf_q <= 1'b1;
            end
          end
        end
        S_INIT: k_q <= k_q + (PtrW+1)'(1);
        S_INIT1: begin
          sp_q <= sp_q + SpW'(1); ini_q <= ini_q + 2'd1;
          // with two points only, the lower chain starts at point 0
          if (ini_q == 2'd0) k_q <= (n_q > CntW'(2)) ? (PtrW+1)'(2) : '0;
          if (ini_q == 2'd1 && n_q == CntW'(2)) begin
            // no more upper points: go straight to lower chain, push point n-2
            lower_q <= 1'b1; top_q <= SpW'(2);
          end
        end
        S_TST: if (!right) sp_q <= sp_q - SpW'(1);
        S_DEC: begin
          sp_q <= sp_q + SpW'(1);
          if (!lower_q) begin
            if (k_q == (PtrW+1)'(n_q - CntW'(1))) begin
              lower_q <= 1'b1; top_q <= sp_q + SpW'(1);
              k_q <= (PtrW+1)'(n_q - CntW'(2));
            end else k_q <= k_q + (PtrW+1)'(1);
          end else k_q <= k_q - (PtrW+1)'(1);
        end
        S_FIN: begin
          if (lower_q && k_q[PtrW]) begin
            ready_q <= 1'b1;
            upper_q <= top_q; chain_q <= sp_q;
          end
        end
        default: ;
      endcase
    end
  end

  // point/anchor capture for turn test
  always_ff @(posedge clk_i) begin
    if (state_q == S_PT) p_q <= pm_rd_q;
    if (state_q == S_TOPA) a_q <= sm_rd_q;
    if (state_q == S_TST && !right) a_q <= a_q;
  end

  logic [6:0] vcnt;
  logic [SaW:0] ridx_q;
  logic       last_fin_q, fin_ovf_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ridx_q <= '0; last_fin_q <= 1'b0; fin_ovf_q <= 1'b0;
    end else begin
      last_fin_q <= acc && cmd_i.opcode == mchull_pkg::OpAdd && cmd_i.final_point;
      if (acc) begin
        ridx_q    <= (SaW+1)'(cmd_i.vertex_index);
        fin_ovf_q <= ovf_q || add_full;
      end
    end
  end
  assign vcnt = ready_q ? 7'(chain_q - SpW'(1)) : 7'd0;

  // result assembly
  always_comb begin
    rsp_o = '0;
    rsp_o.upper_count  = ready_q ? 7'(upper_q) : 7'd0;
    rsp_o.vertex_count = vcnt;
    if (state_q == S_RD) begin
      if (!ready_q) begin
        rsp_o.status = mchull_pkg::StNoHull;
      end else if ((SpW+1)'(ridx_q) >= (SpW+1)'(chain_q - SpW'(1))) begin
        rsp_o.status = mchull_pkg::StRange;
      end else begin
        rsp_o.vertex_x = 16'(sm_rd_q.x);
        rsp_o.vertex_y = 16'(sm_rd_q.y);
      end
    end else if (last_fin_q && !ready_q) begin
      rsp_o.status = fin_ovf_q ? mchull_pkg::StOverflow : mchull_pkg::StFew;
    end else if (ovf_q) begin
      rsp_o.status = mchull_pkg::StOverflow;
    end
  end
endmodule

### src/mchull_turn.sv
// Registered strict right-turn test a -> b -> c: two-stage (products, then compare).
module mchull_turn (
  input  logic                clk_i,
  input  mchull_pkg::pt_t     a_i,
  input  mchull_pkg::pt_t     b_i,
  input  mchull_pkg::pt_t     c_i,
  output logic                right_o
);
  localparam int DW = mchull_pkg::CoordBits + 1;

  logic signed [DW-1:0]   dy1, dy2, dx1, dx2;
  logic signed [2*DW-1:0] p1_q, p2_q;

  assign dy1 = DW'(b_i.y) - DW'(a_i.y);
  assign dy2 = DW'(c_i.y) - DW'(b_i.y);
  assign dx1 = DW'(b_i.x) - DW'(a_i.x);
  assign dx2 = DW'(c_i.x) - DW'(b_i.x);

  // products registered, compared next cycle
  always_ff @(posedge clk_i) begin
    p1_q <= dy1 * dx2;
    p2_q <= dy2 * dx1;
  end

  assign right_o = p1_q > p2_q;
endmodule
